// ===== design/sbrp_pkg.sv =====
// ----------------------------------------------------------------------------
// sbrp_pkg
// Shared types and constants of the STUN binding response parser: parse
// phases, status codes, configuration register indexes and the result record.
// ----------------------------------------------------------------------------
package sbrp_pkg;

    localparam int unsigned HDR_BYTES = 20;
    localparam logic [15:0] ADDR_LEN_V4 = 16'd8;
    localparam logic [15:0] ADDR_LEN_V6 = 16'd20;
    localparam logic [3:0]  POS_SAT = 4'd8;

    typedef enum logic [2:0] {
        PH_HEADER   = 3'd0,
        PH_ATTR_HDR = 3'd1,
        PH_ATTR_VAL = 3'd2,
        PH_DONE     = 3'd3,
        PH_ERROR    = 3'd4
    } t_phase;

    typedef enum logic [2:0] {
        ST_OK       = 3'd0,
        ST_NOT_BIND = 3'd1,
        ST_OVERRUN  = 3'd2,
        ST_BAD_ADDR = 3'd3,
        ST_TRUNC    = 3'd4
    } t_status;

    typedef enum logic [1:0] {
        TGT_NONE    = 2'd0,
        TGT_MAPPED  = 2'd1,
        TGT_CHANGED = 2'd2
    } t_target;

    typedef enum logic [1:0] {
        CFG_BIND_CODE    = 2'd0,
        CFG_MAPPED_CODE  = 2'd1,
        CFG_CHANGED_CODE = 2'd2,
        CFG_FAMILY_CODE  = 2'd3
    } t_cfg_idx;

    typedef struct packed {
        logic [15:0] bind_code;
        logic [15:0] mapped_code;
        logic [15:0] changed_code;
        logic [7:0]  family_code;
    } t_cfg;

    typedef struct packed {
        t_status     status;
        logic        mapped_valid;
        logic [15:0] mapped_udp_port;
        logic [31:0] mapped_ipv4;
        logic        changed_valid;
        logic [15:0] changed_udp_port;
        logic [31:0] changed_ipv4;
    } t_result;

endpackage

// ===== design/sbrp_parser.sv =====
// ----------------------------------------------------------------------------
// sbrp_parser
// Byte-wide STUN parse engine. Updates the header, attribute and capture
// state for each accepted byte and forms the result on the frame end byte.
// ----------------------------------------------------------------------------
module sbrp_parser (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  sbrp_pkg::t_cfg   i_cfg,
    input  logic             i_push,
    input  logic [7:0]       i_data_byte,
    input  logic             i_frame_end,
    output logic             o_res_valid,
    output sbrp_pkg::t_result o_res
);
    import sbrp_pkg::*;

    t_phase      r_phase, n_phase;
    logic [4:0]  r_hdr_idx, n_hdr_idx;
    logic [15:0] r_msg_kind, n_msg_kind;
    logic [15:0] r_body_rem, n_body_rem;
    logic [15:0] r_attr_kind, n_attr_kind;
    logic [15:0] r_attr_size, n_attr_size;
    logic [3:0]  r_pos, n_pos;
    logic [15:0] r_val_left, n_val_left;
    logic [15:0] r_port_gath, n_port_gath;
    logic [31:0] r_addr_gath, n_addr_gath;
    logic        r_map_found, n_map_found;
    logic [15:0] r_map_port, n_map_port;
    logic [31:0] r_map_ip, n_map_ip;
    logic        r_chg_found, n_chg_found;
    logic [15:0] r_chg_port, n_chg_port;
    logic [31:0] r_chg_ip, n_chg_ip;
    t_status     r_err, n_err;

    t_target     target;
    logic [15:0] rem_dec;
    logic [15:0] size_full;
    logic [1:0]  pad_len;
    logic [16:0] padded;
    t_status     fin_status;
    logic        fin_ok;

    // Attribute kind decides the capture slot; mapped wins on equal codes.
    always_comb begin
        if (r_attr_kind == i_cfg.mapped_code) begin
            target = TGT_MAPPED;
        end else if (r_attr_kind == i_cfg.changed_code) begin
            target = TGT_CHANGED;
        end else begin
            target = TGT_NONE;
        end
    end

    assign rem_dec   = r_body_rem - 16'd1;
    assign size_full = {r_attr_size[15:8], i_data_byte};
    assign pad_len   = 2'(~size_full[1:0] + 2'd1);
    assign padded    = {1'b0, size_full} + {15'd0, pad_len};

    always_comb begin
        n_phase     = r_phase;
        n_hdr_idx   = r_hdr_idx;
        n_msg_kind  = r_msg_kind;
        n_body_rem  = r_body_rem;
        n_attr_kind = r_attr_kind;
        n_attr_size = r_attr_size;
        n_pos       = r_pos;
        n_val_left  = r_val_left;
        n_port_gath = r_port_gath;
        n_addr_gath = r_addr_gath;
        n_map_found = r_map_found;
        n_map_port  = r_map_port;
        n_map_ip    = r_map_ip;
        n_chg_found = r_chg_found;
        n_chg_port  = r_chg_port;
        n_chg_ip    = r_chg_ip;
        n_err       = r_err;

        unique case (r_phase)
            PH_HEADER: begin
                if (r_hdr_idx == 5'd0) begin
                    n_msg_kind = {i_data_byte, 8'h00};
                end else if (r_hdr_idx == 5'd1) begin
                    n_msg_kind = {r_msg_kind[15:8], i_data_byte};
                end else if (r_hdr_idx == 5'd2) begin
                    n_body_rem = {i_data_byte, 8'h00};
                end else if (r_hdr_idx == 5'd3) begin
                    n_body_rem = {r_body_rem[15:8], i_data_byte};
                end
                n_hdr_idx = r_hdr_idx + 5'd1;
                if (r_hdr_idx == 5'(HDR_BYTES - 1)) begin
                    n_pos = 4'd0;
                    if (r_msg_kind != i_cfg.bind_code) begin
                        n_err   = ST_NOT_BIND;
                        n_phase = PH_ERROR;
                    end else if (r_body_rem != 16'd0) begin
                        n_phase = PH_ATTR_HDR;
                    end else begin
                        n_phase = PH_DONE;
                    end
                end
            end
            PH_ATTR_HDR: begin
                n_body_rem = rem_dec;
                unique case (r_pos[1:0])
                    2'd0:    n_attr_kind = {i_data_byte, 8'h00};
                    2'd1:    n_attr_kind = {r_attr_kind[15:8], i_data_byte};
                    2'd2:    n_attr_size = {i_data_byte, 8'h00};
                    default: n_attr_size = size_full;
                endcase
                if (r_pos[1:0] != 2'd3) begin
                    n_pos = r_pos + 4'd1;
                    if (rem_dec == 16'd0) begin
                        n_err   = ST_OVERRUN;
                        n_phase = PH_ERROR;
                    end
                end else begin
                    n_pos = 4'd0;
                    if (padded > {1'b0, rem_dec}) begin
                        n_err   = ST_OVERRUN;
                        n_phase = PH_ERROR;
                    end else if (target != TGT_NONE && size_full != ADDR_LEN_V4 &&
                                 size_full != ADDR_LEN_V6) begin
                        n_err   = ST_BAD_ADDR;
                        n_phase = PH_ERROR;
                    end else if (size_full == 16'd0) begin
                        n_phase = (rem_dec != 16'd0) ? PH_ATTR_HDR : PH_DONE;
                    end else begin
                        n_val_left = padded[15:0];
                        n_phase    = PH_ATTR_VAL;
                    end
                end
            end
            PH_ATTR_VAL: begin
                if (target != TGT_NONE && r_pos == 4'd1 &&
                    i_data_byte != i_cfg.family_code) begin
                    n_err   = ST_BAD_ADDR;
                    n_phase = PH_ERROR;
                end else begin
                    if (target != TGT_NONE) begin
                        if (r_pos == 4'd2) begin
                            n_port_gath = {i_data_byte, 8'h00};
                        end else if (r_pos == 4'd3) begin
                            n_port_gath = {r_port_gath[15:8], i_data_byte};
                        end else if (r_pos >= 4'd4 && r_pos <= 4'd7) begin
                            n_addr_gath = {r_addr_gath[23:0], i_data_byte};
                        end
                        if (r_pos == 4'd7) begin
                            if (target == TGT_MAPPED) begin
                                n_map_found = 1'b1;
                                n_map_port  = r_port_gath;
                                n_map_ip    = n_addr_gath;
                            end else begin
                                n_chg_found = 1'b1;
                                n_chg_port  = r_port_gath;
                                n_chg_ip    = n_addr_gath;
                            end
                        end
                    end
                    n_body_rem = rem_dec;
                    n_val_left = r_val_left - 16'd1;
                    n_pos      = (r_pos == POS_SAT) ? POS_SAT : r_pos + 4'd1;
                    if (r_val_left == 16'd1) begin
                        n_pos   = 4'd0;
                        n_phase = (rem_dec != 16'd0) ? PH_ATTR_HDR : PH_DONE;
                    end
                end
            end
            PH_DONE, PH_ERROR: begin
            end
            default: begin
            end
        endcase

        // Final status reflects the state after this byte.
        if (n_err != ST_OK) begin
            fin_status = n_err;
        end else if (n_phase != PH_DONE) begin
            fin_status = ST_TRUNC;
        end else begin
            fin_status = ST_OK;
        end
        fin_ok = (fin_status == ST_OK);

        o_res.status           = fin_status;
        o_res.mapped_valid     = fin_ok && n_map_found;
        o_res.mapped_udp_port  = o_res.mapped_valid ? n_map_port : 16'd0;
        o_res.mapped_ipv4      = o_res.mapped_valid ? n_map_ip : 32'd0;
        o_res.changed_valid    = fin_ok && n_chg_found;
        o_res.changed_udp_port = o_res.changed_valid ? n_chg_port : 16'd0;
        o_res.changed_ipv4     = o_res.changed_valid ? n_chg_ip : 32'd0;

        if (i_frame_end) begin
            n_phase     = PH_HEADER;
            n_hdr_idx   = 5'd0;
            n_body_rem  = 16'd0;
            n_pos       = 4'd0;
            n_map_found = 1'b0;
            n_chg_found = 1'b0;
            n_err       = ST_OK;
        end
    end

    assign o_res_valid = i_push && i_frame_end;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_HEADER;
            r_hdr_idx   <= 5'd0;
            r_body_rem  <= 16'd0;
            r_pos       <= 4'd0;
            r_map_found <= 1'b0;
            r_chg_found <= 1'b0;
            r_err       <= ST_OK;
        end else if (i_push) begin
            r_phase     <= n_phase;
            r_hdr_idx   <= n_hdr_idx;
            r_body_rem  <= n_body_rem;
            r_pos       <= n_pos;
            r_map_found <= n_map_found;
            r_chg_found <= n_chg_found;
            r_err       <= n_err;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_msg_kind  <= n_msg_kind;
            r_attr_kind <= n_attr_kind;
            r_attr_size <= n_attr_size;
            r_val_left  <= n_val_left;
            r_port_gath <= n_port_gath;
            r_addr_gath <= n_addr_gath;
            r_map_port  <= n_map_port;
            r_map_ip    <= n_map_ip;
            r_chg_port  <= n_chg_port;
            r_chg_ip    <= n_chg_ip;
        end
    end

endmodule

// ===== design/sbrp_out_buf.sv =====
// ----------------------------------------------------------------------------
// sbrp_out_buf
// Two-entry result buffer: an output register plus a skid register, so that
// the parser keeps taking bytes while a result waits to be taken.
// ----------------------------------------------------------------------------
module sbrp_out_buf (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  sbrp_pkg::t_result i_res,
    output logic              o_room,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    output sbrp_pkg::t_result o_res
);
    import sbrp_pkg::*;

    logic    r_main_valid;
    t_result r_main;
    logic    r_skid_valid;
    t_result r_skid;
    logic    main_free;

    assign main_free   = !r_main_valid || i_out_ready;
    assign o_room      = !r_skid_valid;
    assign o_out_valid = r_main_valid;
    assign o_res       = r_main;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_main_valid <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (main_free) begin
            if (r_skid_valid) begin
                r_main_valid <= 1'b1;
                r_skid_valid <= 1'b0;
            end else begin
                r_main_valid <= i_push;
            end
        end else if (i_push) begin
            r_skid_valid <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (main_free) begin
            r_main <= r_skid_valid ? r_skid : i_res;
        end
        if (!main_free && i_push) begin
            r_skid <= i_res;
        end
    end

endmodule

// ===== design/stun_binding_response_parser.sv =====
// ----------------------------------------------------------------------------
// stun_binding_response_parser
// Parses a received STUN datagram one byte per transaction and reports one
// status with the captured mapped and changed IPv4 addresses per datagram.
// ----------------------------------------------------------------------------
// The block takes one datagram byte per clock cycle unless stalled, with no
// gaps between datagrams. All parse state is updated in the cycle a byte is
// accepted, by one short stage of counter and field logic, and the result
// for a datagram appears on the output channel the cycle after its frame
// end byte is accepted, unless an earlier result is still waiting there.
// Results go into a two-entry buffer (output register plus skid register),
// so input ready drops only when two results are waiting; with the output
// side draining, the sustained rate is one byte per cycle. The status is 0
// for a good binding response, 1 for a wrong message type, 2 when an
// attribute runs past the body length, 3 for a bad address attribute and 4
// when the datagram ends before the header or body is complete. The first
// error seen wins. Port and address fields are zero unless their valid bit
// is set, which happens only with a good status. Bytes after the body are
// ignored. The user must write the four code registers via the configuration
// channel, always ready, only while the block is idle; this is not enforced.
// ----------------------------------------------------------------------------
module stun_binding_response_parser (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [7:0]  i_data_byte,
    input  logic        i_frame_end,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [2:0]  o_status,
    output logic        o_mapped_valid,
    output logic [15:0] o_mapped_port,
    output logic [31:0] o_mapped_ipv4,
    output logic        o_changed_valid,
    output logic [15:0] o_changed_port,
    output logic [31:0] o_changed_ipv4,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [1:0]  i_cfg_index,
    input  logic [15:0] i_cfg_data
);
    import sbrp_pkg::*;

    t_cfg    r_cfg;
    logic    push;
    logic    res_valid;
    t_result res;
    t_result out_res;
    logic    room;

    // Configuration registers. Every index names a register, so each write
    // lands somewhere; the family code keeps the low byte of the data.
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.bind_code    <= 16'd257;
            r_cfg.mapped_code  <= 16'd1;
            r_cfg.changed_code <= 16'd5;
            r_cfg.family_code  <= 8'd1;
        end else if (i_cfg_valid) begin
            unique case (t_cfg_idx'(i_cfg_index))
                CFG_BIND_CODE:    r_cfg.bind_code    <= i_cfg_data;
                CFG_MAPPED_CODE:  r_cfg.mapped_code  <= i_cfg_data;
                CFG_CHANGED_CODE: r_cfg.changed_code <= i_cfg_data;
                CFG_FAMILY_CODE:  r_cfg.family_code  <= i_cfg_data[7:0];
                default:          r_cfg.bind_code    <= r_cfg.bind_code;
            endcase
        end
    end

    // A byte is taken whenever the result buffer can still hold one more
    // result; only frame end bytes actually produce one.
    assign o_in_ready = room;
    assign push       = i_in_valid && room;

    sbrp_parser u_parser (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (r_cfg),
        .i_push      (push),
        .i_data_byte (i_data_byte),
        .i_frame_end (i_frame_end),
        .o_res_valid (res_valid),
        .o_res       (res)
    );

    sbrp_out_buf u_out_buf (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (res_valid),
        .i_res       (res),
        .o_room      (room),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_res       (out_res)
    );

    assign o_status        = out_res.status;
    assign o_mapped_valid  = out_res.mapped_valid;
    assign o_mapped_port   = out_res.mapped_udp_port;
    assign o_mapped_ipv4   = out_res.mapped_ipv4;
    assign o_changed_valid = out_res.changed_valid;
    assign o_changed_port  = out_res.changed_udp_port;
    assign o_changed_ipv4  = out_res.changed_ipv4;

endmodule

// ===== tb/sv/sbrp_frame_checker.sv =====
// ----------------------------------------------------------------------------
// sbrp_frame_checker
// Watches the byte, result and configuration channels of the STUN binding
// response parser, predicts one report per datagram and compares each report.
// ----------------------------------------------------------------------------
module sbrp_frame_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    input  logic        i_in_ready,
    input  logic [7:0]  i_data_byte,
    input  logic        i_frame_end,
    input  logic        i_out_valid,
    input  logic        i_out_ready,
    input  logic [2:0]  i_status,
    input  logic        i_mapped_valid,
    input  logic [15:0] i_mapped_port,
    input  logic [31:0] i_mapped_ipv4,
    input  logic        i_changed_valid,
    input  logic [15:0] i_changed_port,
    input  logic [31:0] i_changed_ipv4,
    input  logic        i_cfg_valid,
    input  logic        i_cfg_ready,
    input  logic [1:0]  i_cfg_index,
    input  logic [15:0] i_cfg_data,
    output int          o_fail_count,
    output int          o_pending
);

    timeunit 1ns;
    timeprecision 1ps;

    import sbrp_pkg::*;

    localparam logic [15:0] RST_BIND_CODE    = 16'h0101;
    localparam logic [15:0] RST_MAPPED_CODE  = 16'h0001;
    localparam logic [15:0] RST_CHANGED_CODE = 16'h0005;
    localparam logic [7:0]  RST_FAMILY_CODE  = 8'h01;

    t_cfg        codes;
    t_phase      phase;
    t_status     error_status;
    logic [4:0]  hdr_count;
    logic [15:0] msg_word;
    logic [15:0] body_left;
    logic [15:0] attr_type;
    logic [15:0] attr_len;
    logic [15:0] attr_pos;
    logic [15:0] port_acc;
    logic [31:0] addr_acc;
    logic        mapped_seen;
    logic [15:0] mapped_port_q;
    logic [31:0] mapped_addr_q;
    logic        changed_seen;
    logic [15:0] changed_port_q;
    logic [31:0] changed_addr_q;

    t_result     reports_due[$];
    int          mismatch_count = 0;
    int          reports_seen = 0;

    function automatic t_target target_of(input logic [15:0] kind);
        if (kind == codes.mapped_code) begin
            return TGT_MAPPED;
        end
        if (kind == codes.changed_code) begin
            return TGT_CHANGED;
        end
        return TGT_NONE;
    endfunction

    // Attribute values are padded up to a multiple of four bytes.
    function automatic logic [16:0] padded_len(input logic [15:0] len);
        return {1'b0, len} + {15'd0, 2'd0 - len[1:0]};
    endfunction

    task automatic clear_frame();
        phase          = PH_HEADER;
        error_status   = ST_OK;
        hdr_count      = '0;
        msg_word       = '0;
        body_left      = '0;
        attr_type      = '0;
        attr_len       = '0;
        attr_pos       = '0;
        port_acc       = '0;
        addr_acc       = '0;
        mapped_seen    = 1'b0;
        mapped_port_q  = '0;
        mapped_addr_q  = '0;
        changed_seen   = 1'b0;
        changed_port_q = '0;
        changed_addr_q = '0;
    endtask

    task automatic flag_error(input t_status code);
        error_status = code;
        phase        = PH_ERROR;
    endtask

    task automatic next_attr();
        attr_pos = '0;
        phase    = (body_left != 16'd0) ? PH_ATTR_HDR : PH_DONE;
    endtask

    // Advances the parse state by one datagram byte.
    task automatic consume_byte(input logic [7:0] b);
        t_target tgt;
        logic [16:0] span;
        case (phase)
            PH_HEADER: begin
                case (hdr_count)
                    5'd0: msg_word = {b, 8'h00};
                    5'd1: msg_word[7:0] = b;
                    5'd2: body_left = {b, 8'h00};
                    5'd3: body_left[7:0] = b;
                    default: ;
                endcase
                hdr_count = hdr_count + 5'd1;
                if (hdr_count >= HDR_BYTES) begin
                    if (msg_word != codes.bind_code) begin
                        flag_error(ST_NOT_BIND);
                    end else begin
                        next_attr();
                    end
                end
            end
            PH_ATTR_HDR: begin
                case (attr_pos)
                    16'd0: attr_type = {b, 8'h00};
                    16'd1: attr_type[7:0] = b;
                    16'd2: attr_len = {b, 8'h00};
                    default: attr_len[7:0] = b;
                endcase
                body_left = body_left - 16'd1;
                attr_pos  = attr_pos + 16'd1;
                span = padded_len(attr_len);
                tgt  = target_of(attr_type);
                if (attr_pos < 16'd4) begin
                    if (body_left == 16'd0) begin
                        flag_error(ST_OVERRUN);
                    end
                end else if (span > {1'b0, body_left}) begin
                    flag_error(ST_OVERRUN);
                end else if (tgt != TGT_NONE && attr_len != ADDR_LEN_V4 &&
                             attr_len != ADDR_LEN_V6) begin
                    flag_error(ST_BAD_ADDR);
                end else if (span == 17'd0) begin
                    next_attr();
                end else begin
                    attr_pos = '0;
                    phase    = PH_ATTR_VAL;
                end
            end
            PH_ATTR_VAL: begin
                tgt = target_of(attr_type);
                if (tgt != TGT_NONE && attr_pos == 16'd1 && b != codes.family_code) begin
                    flag_error(ST_BAD_ADDR);
                end else begin
                    if (tgt != TGT_NONE) begin
                        case (attr_pos)
                            16'd2: port_acc = {b, 8'h00};
                            16'd3: port_acc[7:0] = b;
                            16'd4, 16'd5, 16'd6, 16'd7: addr_acc = {addr_acc[23:0], b};
                            default: ;
                        endcase
                        // The eighth value byte completes the capture.
                        if (attr_pos == 16'd7) begin
                            if (tgt == TGT_MAPPED) begin
                                mapped_seen   = 1'b1;
                                mapped_port_q = port_acc;
                                mapped_addr_q = addr_acc;
                            end else begin
                                changed_seen   = 1'b1;
                                changed_port_q = port_acc;
                                changed_addr_q = addr_acc;
                            end
                        end
                    end
                    body_left = body_left - 16'd1;
                    attr_pos  = attr_pos + 16'd1;
                    if ({1'b0, attr_pos} >= padded_len(attr_len)) begin
                        next_attr();
                    end
                end
            end
            default: ;
        endcase
    endtask

    function automatic t_result frame_report();
        t_result r;
        t_status s;
        if (error_status != ST_OK) begin
            s = error_status;
        end else if (phase != PH_DONE) begin
            s = ST_TRUNC;
        end else begin
            s = ST_OK;
        end
        r = '0;
        r.status = s;
        if (s == ST_OK && mapped_seen) begin
            r.mapped_valid    = 1'b1;
            r.mapped_udp_port = mapped_port_q;
            r.mapped_ipv4     = mapped_addr_q;
        end
        if (s == ST_OK && changed_seen) begin
            r.changed_valid    = 1'b1;
            r.changed_udp_port = changed_port_q;
            r.changed_ipv4     = changed_addr_q;
        end
        return r;
    endfunction

    // Each mismatch prints one line and is counted.
    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("[%0t] report %0d: %s is 0x%0h, predicted 0x%0h",
                 $time, reports_seen, what, got, want);
        mismatch_count++;
    endtask

    task automatic check_report();
        t_result want;
        if (reports_due.size() == 0) begin
            report_mismatch("report with no datagram pending, status", 32'(i_status), 32'd0);
        end else begin
            want = reports_due.pop_front();
            if (i_status !== want.status)
                report_mismatch("status", 32'(i_status), 32'(want.status));
            if (i_mapped_valid !== want.mapped_valid)
                report_mismatch("mapped valid", 32'(i_mapped_valid), 32'(want.mapped_valid));
            if (i_mapped_port !== want.mapped_udp_port)
                report_mismatch("mapped port", 32'(i_mapped_port),
                                32'(want.mapped_udp_port));
            if (i_mapped_ipv4 !== want.mapped_ipv4)
                report_mismatch("mapped address", i_mapped_ipv4, want.mapped_ipv4);
            if (i_changed_valid !== want.changed_valid)
                report_mismatch("changed valid", 32'(i_changed_valid),
                                32'(want.changed_valid));
            if (i_changed_port !== want.changed_udp_port)
                report_mismatch("changed port", 32'(i_changed_port),
                                32'(want.changed_udp_port));
            if (i_changed_ipv4 !== want.changed_ipv4)
                report_mismatch("changed address", i_changed_ipv4, want.changed_ipv4);
        end
        reports_seen++;
    endtask

    // Reports are checked before a new datagram end is recorded, so a report
    // leaving at the same edge is always matched against an older datagram.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            codes.bind_code    = RST_BIND_CODE;
            codes.mapped_code  = RST_MAPPED_CODE;
            codes.changed_code = RST_CHANGED_CODE;
            codes.family_code  = RST_FAMILY_CODE;
            clear_frame();
            reports_due.delete();
        end else begin
            if (i_out_valid && i_out_ready) begin
                check_report();
            end
            if (i_cfg_valid && i_cfg_ready) begin
                case (i_cfg_index)
                    CFG_BIND_CODE:    codes.bind_code    = i_cfg_data;
                    CFG_MAPPED_CODE:  codes.mapped_code  = i_cfg_data;
                    CFG_CHANGED_CODE: codes.changed_code = i_cfg_data;
                    CFG_FAMILY_CODE:  codes.family_code  = i_cfg_data[7:0];
                    default: ;
                endcase
            end
            if (i_in_valid && i_in_ready) begin
                consume_byte(i_data_byte);
                if (i_frame_end) begin
                    reports_due.push_back(frame_report());
                    clear_frame();
                end
            end
        end
        o_fail_count <= mismatch_count;
        o_pending    <= reports_due.size();
    end

endmodule

// ===== tb/sv/tb_stun_binding_response_parser.sv =====
// ----------------------------------------------------------------------------
// tb_stun_binding_response_parser
// Drives datagrams into the STUN binding response parser under random idling
// and backpressure; a checker beside the block predicts and compares reports.
// ----------------------------------------------------------------------------
module tb_stun_binding_response_parser;

    timeunit 1ns;
    timeprecision 1ps;

    import sbrp_pkg::*;

    // Code register values after reset.
    localparam logic [15:0] RST_BIND_CODE    = 16'h0101;
    localparam logic [15:0] RST_MAPPED_CODE  = 16'h0001;
    localparam logic [15:0] RST_CHANGED_CODE = 16'h0005;
    localparam logic [15:0] RST_FAMILY_WORD  = 16'h0001;

    // The long receiver hold-off, in cycles. It is much longer than the time
    // the block needs to fill its two result slots with short datagrams.
    localparam int HOLD_CYCLES = 200;

    // Random datagrams keep coming until this many bytes have been sent in
    // total, before the closing full-rate datagrams.
    localparam int BULK_BYTES = 760;

    // Generous run limit. A correct run sends under 1100 bytes; even with every
    // byte behind the longest sender gap, every report behind the longest
    // receiver stall and the long hold-off it stays far below this.
    localparam int CYCLE_LIMIT = 400000;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_in_valid = 1'b0;
    logic        o_in_ready;
    logic [7:0]  i_data_byte = 8'h00;
    logic        i_frame_end = 1'b0;
    logic        o_out_valid;
    logic        i_out_ready = 1'b0;
    logic [2:0]  o_status;
    logic        o_mapped_valid;
    logic [15:0] o_mapped_port;
    logic [31:0] o_mapped_ipv4;
    logic        o_changed_valid;
    logic [15:0] o_changed_port;
    logic [31:0] o_changed_ipv4;
    logic        i_cfg_valid = 1'b0;
    logic        o_cfg_ready;
    logic [1:0]  i_cfg_index = CFG_BIND_CODE;
    logic [15:0] i_cfg_data = 16'h0000;

    int          fail_count;
    int          pending;

    // Local copy of the code registers, used only to build datagrams that
    // the block will recognize under the current setting.
    logic [15:0] bind_code = RST_BIND_CODE;
    logic [15:0] map_code  = RST_MAPPED_CODE;
    logic [15:0] chg_code  = RST_CHANGED_CODE;
    logic [7:0]  fam_code  = RST_FAMILY_WORD[7:0];

    // Idling controls; two are shared by the main sequence and the sink process.
    bit          idle_on = 1'b1;
    bit          stall_on = 1'b1;
    bit          hold_request = 1'b0;

    logic [7:0]  body_buf[$];
    logic [7:0]  frame_buf[$];
    int          bytes_sent = 0;
    int          cycle_count = 0;

    stun_binding_response_parser dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (i_in_valid),
        .o_in_ready      (o_in_ready),
        .i_data_byte     (i_data_byte),
        .i_frame_end     (i_frame_end),
        .o_out_valid     (o_out_valid),
        .i_out_ready     (i_out_ready),
        .o_status        (o_status),
        .o_mapped_valid  (o_mapped_valid),
        .o_mapped_port   (o_mapped_port),
        .o_mapped_ipv4   (o_mapped_ipv4),
        .o_changed_valid (o_changed_valid),
        .o_changed_port  (o_changed_port),
        .o_changed_ipv4  (o_changed_ipv4),
        .i_cfg_valid     (i_cfg_valid),
        .o_cfg_ready     (o_cfg_ready),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data)
    );

    sbrp_frame_checker checker_inst (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (i_in_valid),
        .i_in_ready      (o_in_ready),
        .i_data_byte     (i_data_byte),
        .i_frame_end     (i_frame_end),
        .i_out_valid     (o_out_valid),
        .i_out_ready     (i_out_ready),
        .i_status        (o_status),
        .i_mapped_valid  (o_mapped_valid),
        .i_mapped_port   (o_mapped_port),
        .i_mapped_ipv4   (o_mapped_ipv4),
        .i_changed_valid (o_changed_valid),
        .i_changed_port  (o_changed_port),
        .i_changed_ipv4  (o_changed_ipv4),
        .i_cfg_valid     (i_cfg_valid),
        .i_cfg_ready     (o_cfg_ready),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data),
        .o_fail_count    (fail_count),
        .o_pending       (pending)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // Watchdog: a hung handshake ends the run as a failure.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("simulation failed");
            $finish;
        end
    end

    // Result sink. Ready alternates between open stretches and random stall
    // bursts. When the main sequence asks for a long hold-off, ready stays low
    // for the whole hold-off, counted here, while bytes keep coming on the input
    // side. Every branch makes one assignment and then waits on the clock, so
    // ready never gets two updates in one step.
    initial begin
        @(posedge i_clk);
        forever begin
            if (hold_request) begin
                i_out_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
                hold_request = 1'b0;
            end else if (stall_on && $urandom_range(0, 4) == 0) begin
                i_out_ready <= 1'b0;
                repeat ($urandom_range(1, 14)) @(posedge i_clk);
            end else begin
                i_out_ready <= 1'b1;
                repeat ($urandom_range(1, 24)) @(posedge i_clk);
            end
        end
    end

    // Offers one byte and returns at the edge where the transaction is
    // accepted. Valid is left high: the caller either offers the next byte
    // or drops valid in that same step.
    task automatic send_byte(input logic [7:0] b, input logic last);
        if (idle_on && $urandom_range(0, 9) == 0) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 14)) @(posedge i_clk);
        end
        i_in_valid  <= 1'b1;
        i_data_byte <= b;
        i_frame_end <= last;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        bytes_sent++;
    endtask

    // Stops offering bytes and waits until every report has left the block.
    // A report is registered in the output buffer after its last byte; the
    // extra wait at the end covers bytes that cause no report.
    task automatic drain();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    // One configuration transaction. Valid stays high for a following write.
    task automatic write_reg(input t_cfg_idx idx, input logic [15:0] word);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= word;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
    endtask

    // Writes all four code registers. Only called with the block idle.
    // The family register keeps the low byte of its data word.
    task automatic program_codes(input logic [15:0] bind_word, input logic [15:0] map_word,
                                 input logic [15:0] chg_word, input logic [15:0] fam_word);
        write_reg(CFG_BIND_CODE, bind_word);
        write_reg(CFG_MAPPED_CODE, map_word);
        write_reg(CFG_CHANGED_CODE, chg_word);
        write_reg(CFG_FAMILY_CODE, fam_word);
        i_cfg_valid <= 1'b0;
        bind_code = bind_word;
        map_code  = map_word;
        chg_code  = chg_word;
        fam_code  = fam_word[7:0];
    endtask

    // Ports and addresses lean toward the all-zero and all-one extremes.
    function automatic logic [15:0] draw_port();
        case ($urandom_range(0, 5))
            0: return 16'h0000;
            1: return 16'hFFFF;
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic logic [31:0] draw_addr();
        case ($urandom_range(0, 5))
            0: return 32'h0000_0000;
            1: return 32'hFFFF_FFFF;
            default: return $urandom;
        endcase
    endfunction

    // Appends an address attribute to the body: type and length, then pad byte,
    // family, port and IPv4 address and random filler up to the padded length.
    task automatic add_addr_attr(input logic [15:0] code, input logic [15:0] len,
                                 input logic [7:0] family, input logic [15:0] port,
                                 input logic [31:0] addr);
        int span;
        span = int'(len) + ((4 - (int'(len) % 4)) % 4);
        body_buf.push_back(code[15:8]);
        body_buf.push_back(code[7:0]);
        body_buf.push_back(len[15:8]);
        body_buf.push_back(len[7:0]);
        for (int k = 0; k < span; k++) begin
            case (k)
                1: body_buf.push_back(family);
                2: body_buf.push_back(port[15:8]);
                3: body_buf.push_back(port[7:0]);
                4: body_buf.push_back(addr[31:24]);
                5: body_buf.push_back(addr[23:16]);
                6: body_buf.push_back(addr[15:8]);
                7: body_buf.push_back(addr[7:0]);
                default: body_buf.push_back(8'($urandom));
            endcase
        end
    endtask

    task automatic add_raw_attr(input logic [15:0] code, input logic [15:0] len);
        int span;
        span = int'(len) + ((4 - (int'(len) % 4)) % 4);
        body_buf.push_back(code[15:8]);
        body_buf.push_back(code[7:0]);
        body_buf.push_back(len[15:8]);
        body_buf.push_back(len[7:0]);
        repeat (span) body_buf.push_back(8'($urandom));
    endtask

    // Wraps the body in a header and sends the datagram. A negative length
    // field means the true body length; keep cuts the datagram short (zero
    // keeps it all); trail appends bytes beyond the body. The last byte sent
    // carries the frame end flag.
    task automatic ship_frame(input logic [15:0] kind, input int len_field,
                              input int keep, input int trail);
        logic [15:0] len_word;
        int n;
        len_word = (len_field < 0) ? 16'(body_buf.size()) : 16'(len_field);
        frame_buf.delete();
        frame_buf.push_back(kind[15:8]);
        frame_buf.push_back(kind[7:0]);
        frame_buf.push_back(len_word[15:8]);
        frame_buf.push_back(len_word[7:0]);
        repeat (16) frame_buf.push_back(8'($urandom));
        foreach (body_buf[k]) frame_buf.push_back(body_buf[k]);
        repeat (trail) frame_buf.push_back(8'($urandom));
        n = frame_buf.size();
        if (keep > 0 && keep < n) begin
            n = keep;
        end
        for (int k = 0; k < n; k++) begin
            send_byte(frame_buf[k], k == n - 1);
        end
        body_buf.delete();
    endtask

    // Mostly well-formed binding responses with random attributes, with a
    // minority of wrong message types, bad families, bad address lengths,
    // wrong body lengths, trailing bytes and cut-short datagrams.
    task automatic random_frame();
        int mode;
        int len_field;
        int keep;
        int trail;
        logic [15:0] kind;
        repeat ($urandom_range(0, 3)) begin
            mode = $urandom_range(0, 19);
            if (mode < 7) begin
                add_addr_attr(map_code, ($urandom_range(0, 4) == 0) ? ADDR_LEN_V6 : ADDR_LEN_V4,
                              ($urandom_range(0, 24) == 0) ? 8'($urandom) : fam_code,
                              draw_port(), draw_addr());
            end else if (mode < 13) begin
                add_addr_attr(chg_code, ($urandom_range(0, 4) == 0) ? ADDR_LEN_V6 : ADDR_LEN_V4,
                              ($urandom_range(0, 24) == 0) ? 8'($urandom) : fam_code,
                              draw_port(), draw_addr());
            end else if (mode < 19) begin
                add_raw_attr(16'($urandom), 16'($urandom_range(0, 10)));
            end else begin
                add_addr_attr($urandom_range(0, 1) ? map_code : chg_code,
                              16'($urandom_range(0, 24)), fam_code, draw_port(), draw_addr());
            end
        end
        kind = ($urandom_range(0, 15) == 0) ? 16'($urandom) : bind_code;
        mode = $urandom_range(0, 19);
        len_field = -1;
        if (mode == 0) begin
            len_field = body_buf.size() + $urandom_range(1, 8);
        end else if (mode == 1) begin
            len_field = $urandom_range(0, body_buf.size());
        end else if (mode == 2) begin
            len_field = $urandom_range(0, 65535);
        end
        trail = ($urandom_range(0, 4) == 0) ? $urandom_range(1, 6) : 0;
        keep  = ($urandom_range(0, 11) == 0) ? $urandom_range(1, 20 + body_buf.size()) : 0;
        ship_frame(kind, len_field, keep, trail);
    endtask

    initial begin
        int phase_frames;

        // Synchronous reset, applied once.
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // ---- Directed datagrams under the reset codes ----

        // A header with an empty body is a complete, good response.
        ship_frame(bind_code, -1, 0, 0);
        // Both addresses, with port and address at their extremes.
        add_addr_attr(map_code, ADDR_LEN_V4, fam_code, 16'hFFFF, 32'hFFFF_FFFF);
        add_addr_attr(chg_code, ADDR_LEN_V4, fam_code, 16'h0000, 32'h0000_0000);
        ship_frame(bind_code, -1, 0, 0);
        // Wrong message type, detected at the last header byte.
        add_addr_attr(map_code, ADDR_LEN_V4, fam_code, draw_port(), draw_addr());
        ship_frame(~bind_code, -1, 0, 0);
        // Datagrams that end inside the header: one byte, then seven.
        ship_frame(bind_code, -1, 1, 0);
        ship_frame(bind_code, -1, 7, 0);
        // The body claims the largest length but the datagram ends early.
        add_raw_attr(16'h8022, 16'd4);
        ship_frame(bind_code, 65535, 0, 0);
        // The body ends inside an attribute header.
        add_raw_attr(16'h0020, 16'd0);
        ship_frame(bind_code, 2, 0, 0);
        // The padded value is longer than what is left of the body.
        add_addr_attr(map_code, ADDR_LEN_V4, fam_code, draw_port(), draw_addr());
        ship_frame(bind_code, 8, 0, 0);
        // Address lengths that are neither 8 nor 20, including zero.
        add_addr_attr(chg_code, 16'd12, fam_code, draw_port(), draw_addr());
        ship_frame(bind_code, -1, 0, 0);
        add_addr_attr(map_code, 16'd0, fam_code, draw_port(), draw_addr());
        ship_frame(bind_code, -1, 0, 0);
        // Family byte other than IPv4.
        add_addr_attr(map_code, ADDR_LEN_V4, ~fam_code, draw_port(), draw_addr());
        ship_frame(bind_code, -1, 0, 0);
        // A 20-byte address value: only its first eight bytes count.
        add_addr_attr(map_code, ADDR_LEN_V6, fam_code, draw_port(), draw_addr());
        ship_frame(bind_code, -1, 0, 0);
        // A later mapped address overwrites an earlier one; the unknown
        // attribute between them has an odd length and gets padded.
        add_addr_attr(map_code, ADDR_LEN_V4, fam_code, 16'h1234, 32'h0A00_0001);
        add_raw_attr(16'h8020, 16'd5);
        add_addr_attr(map_code, ADDR_LEN_V4, fam_code, 16'hABCD, 32'hC0A8_0102);
        ship_frame(bind_code, -1, 0, 0);
        // Bytes after the body are ignored.
        add_addr_attr(chg_code, ADDR_LEN_V4, fam_code, draw_port(), draw_addr());
        ship_frame(bind_code, -1, 0, 5);
        // The first error wins: a bad family ahead of an attribute that
        // would run past the body.
        add_addr_attr(map_code, ADDR_LEN_V4, ~fam_code, draw_port(), draw_addr());
        add_raw_attr(16'h0003, 16'd40);
        ship_frame(bind_code, body_buf.size() - 8, 0, 0);
        // A zero-length unknown attribute closes the body exactly.
        add_raw_attr(16'h8888, 16'd0);
        ship_frame(bind_code, -1, 0, 0);
        // Cut short inside the body.
        add_addr_attr(chg_code, ADDR_LEN_V4, fam_code, draw_port(), draw_addr());
        ship_frame(bind_code, -1, 26, 0);

        // ---- Extreme code settings ----

        // All-ones message type and mapped code, zero changed code.
        drain();
        program_codes(16'hFFFF, 16'hFFFF, 16'h0000, 16'h00FF);
        random_frame();

        // All codes zero, so mapped and changed codes are equal and every
        // address attribute counts as mapped. The family data word carries
        // set upper bits that the register must drop.
        drain();
        program_codes(16'h0000, 16'h0000, 16'h0000, 16'hFF00);
        add_addr_attr(chg_code, ADDR_LEN_V4, fam_code, draw_port(), draw_addr());
        ship_frame(bind_code, -1, 0, 0);
        random_frame();

        // ---- Backpressure ----

        // The sink holds off for a long stretch while short datagrams keep
        // arriving, so both result slots fill and the block stalls its input.
        drain();
        program_codes(RST_BIND_CODE, RST_MAPPED_CODE, RST_CHANGED_CODE, RST_FAMILY_WORD);
        hold_request = 1'b1;
        repeat (3) begin
            ship_frame(bind_code, -1, 1, 0);
            ship_frame(bind_code, -1, 0, 0);
        end

        // ---- Random datagrams ----

        // Every four datagrams the block is drained and the codes are
        // reprogrammed, half of the time back to their reset values.
        phase_frames = 4;
        while (bytes_sent < BULK_BYTES) begin
            if (phase_frames == 4) begin
                drain();
                if ($urandom_range(0, 1) == 0) begin
                    program_codes(RST_BIND_CODE, RST_MAPPED_CODE, RST_CHANGED_CODE,
                                  RST_FAMILY_WORD);
                end else begin
                    program_codes(16'($urandom), 16'($urandom), 16'($urandom),
                                  16'($urandom));
                end
                phase_frames = 0;
            end
            random_frame();
            phase_frames++;
        end

        // ---- Full rate: no idling on either side ----

        idle_on  = 1'b0;
        stall_on = 1'b0;
        repeat (2) random_frame();

        drain();
        repeat (8) @(posedge i_clk);
        if (fail_count == 0 && pending == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule
